/* hdl/dfhe_pkg.sv */
package dfhe_pkg;

   // Default queue depths.
   localparam int TOKEN_DEPTH  = 4;
   localparam int RESULT_DEPTH = 2;

   // A match token is at most 8 + 5 + 5 + 13 bits.
   localparam int TOK_BITS_W  = 31;
   localparam int TOK_COUNT_W = 5;
   // Up to seven pending bits plus one full token.
   localparam int ACC_W       = 38;
   localparam int ACC_COUNT_W = 6;

   typedef enum logic [2:0] {
      ACT_BLOCK_START  = 3'd0,
      ACT_LITERAL      = 3'd1,
      ACT_MATCH        = 3'd2,
      ACT_END_OF_BLOCK = 3'd3,
      ACT_FLUSH        = 3'd4
   } action_type;

   localparam logic [8:0]  SYM_END_OF_BLOCK = 9'd256;
   localparam logic [8:0]  SYM_LEN_FIRST    = 9'd257;
   localparam logic [8:0]  LEN_MIN          = 9'd3;
   localparam logic [8:0]  LEN_MAX          = 9'd258;
   localparam logic [15:0] DIST_MIN         = 16'd1;
   localparam logic [15:0] DIST_MAX         = 16'd32768;
   localparam logic [3:0]  BLOCK_HEAD_BITS  = 4'd3;
   localparam logic [4:0]  DIST_CODE_BITS   = 5'd5;

   localparam logic [8:0] LEN_BASE [0:28] = '{
      9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
      9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
      9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
   };
   localparam logic [2:0] LEN_EXTRA [0:28] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd0
   };
   localparam logic [15:0] DIST_BASE [0:29] = '{
      16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
      16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385,
      16'd513, 16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097,
      16'd6145, 16'd8193, 16'd12289, 16'd16385, 16'd24577
   };
   localparam logic [3:0] DIST_EXTRA [0:29] = '{
      4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
      4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
      4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
   };

   typedef struct packed {
      logic [8:0] code;   // already reversed, first bit in bit 0
      logic [3:0] n;
   } litlen_code_type;

   // Classified item between the two front stages.
   typedef struct packed {
      logic [8:0]  head_code;
      logic [3:0]  head_n;
      logic [4:0]  len_ext;
      logic [2:0]  len_ext_n;
      logic [4:0]  dist_rev;
      logic [12:0] dist_ext;
      logic [3:0]  dist_ext_n;
      logic        is_match;
      logic        is_flush;
   } front_type;

   typedef struct packed {
      logic [TOK_BITS_W-1:0]  bits;
      logic [TOK_COUNT_W-1:0] count;
      logic                   flush;
   } token_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } result_type;

   // Fixed literal/length code, reversed so that the code's MSB goes out first.
   function automatic litlen_code_type litlen_code(input logic [8:0] sym);
      litlen_code_type r;
      logic [8:0]      code;
      logic [8:0]      rev;
      priority if (sym <= 9'd143) begin
         code = sym + 9'h030;
         r.n  = 4'd8;
      end else if (sym <= 9'd255) begin
         code = sym - 9'd144 + 9'h190;
         r.n  = 4'd9;
      end else if (sym <= 9'd279) begin
         code = sym - 9'd256;
         r.n  = 4'd7;
      end else begin
         code = sym - 9'd280 + 9'h0C0;
         r.n  = 4'd8;
      end
      for (int i = 0; i < 9; i++) begin
         rev[i] = code[8-i];
      end
      r.code = rev >> (4'd9 - r.n);
      return r;
   endfunction

endpackage

/* hdl/dfhe_fifo.sv */
module dfhe_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/dfhe_front.sv */
module dfhe_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [2:0]           req_action,
   input  logic                 req_final_block,
   input  logic [7:0]           req_literal_byte,
   input  logic [8:0]           req_copy_length,
   input  logic [15:0]          req_copy_distance,
   output logic                 tok_push,
   output dfhe_pkg::token_type  tok_data,
   input  logic                 tok_full
);

   dfhe_pkg::front_type       stage_ff, stage_in;
   logic                      stage_valid_ff, stage_valid_in;
   logic                      advance, accept;
   logic [8:0]                len_sat;
   logic [15:0]               dist_sat;
   logic [4:0]                lc, dc;
   dfhe_pkg::litlen_code_type head;
   logic                      known;
   logic [4:0]                off_len, off_dist_code, off_dist_ext;

   // Stage A classifies the item; stage B assembles its bits into a token.
   assign advance = !stage_valid_ff || !tok_full;
   assign req_full = !advance;
   assign accept  = req_push && advance;

   always_comb begin
      len_sat = req_copy_length;
      if (req_copy_length < dfhe_pkg::LEN_MIN) begin
         len_sat = dfhe_pkg::LEN_MIN;
      end else if (req_copy_length > dfhe_pkg::LEN_MAX) begin
         len_sat = dfhe_pkg::LEN_MAX;
      end
      dist_sat = req_copy_distance;
      if (req_copy_distance < dfhe_pkg::DIST_MIN) begin
         dist_sat = dfhe_pkg::DIST_MIN;
      end else if (req_copy_distance > dfhe_pkg::DIST_MAX) begin
         dist_sat = dfhe_pkg::DIST_MAX;
      end
      lc = '0;
      for (int i = 1; i < 29; i++) begin
         if (dfhe_pkg::LEN_BASE[i] <= len_sat) begin
            lc = 5'(i);
         end
      end
      dc = '0;
      for (int i = 1; i < 30; i++) begin
         if (dfhe_pkg::DIST_BASE[i] <= dist_sat) begin
            dc = 5'(i);
         end
      end
   end

   always_comb begin
      stage_in            = '0;
      known               = 1'b1;
      head                = dfhe_pkg::litlen_code({1'b0, req_literal_byte});
      stage_in.len_ext    = 5'(len_sat - dfhe_pkg::LEN_BASE[lc]);
      stage_in.len_ext_n  = dfhe_pkg::LEN_EXTRA[lc];
      stage_in.dist_rev   = {dc[0], dc[1], dc[2], dc[3], dc[4]};
      stage_in.dist_ext   = 13'(dist_sat - dfhe_pkg::DIST_BASE[dc]);
      stage_in.dist_ext_n = dfhe_pkg::DIST_EXTRA[dc];
      unique case (dfhe_pkg::action_type'(req_action))
         dfhe_pkg::ACT_BLOCK_START: begin
            // BFINAL first, then BTYPE = 01.
            head.code = {7'd1, req_final_block};
            head.n    = dfhe_pkg::BLOCK_HEAD_BITS;
         end
         dfhe_pkg::ACT_LITERAL: begin
         end
         dfhe_pkg::ACT_MATCH: begin
            head              = dfhe_pkg::litlen_code(dfhe_pkg::SYM_LEN_FIRST + 9'(lc));
            stage_in.is_match = 1'b1;
         end
         dfhe_pkg::ACT_END_OF_BLOCK: begin
            head = dfhe_pkg::litlen_code(dfhe_pkg::SYM_END_OF_BLOCK);
         end
         dfhe_pkg::ACT_FLUSH: begin
            stage_in.is_flush = 1'b1;
         end
         default: begin
            known = 1'b0;
         end
      endcase
      stage_in.head_code = head.code;
      stage_in.head_n    = head.n;
   end

   // Unused action codes are taken and dropped.
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (advance) begin
         stage_valid_in = accept && known;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   always_comb begin
      off_len       = 5'(stage_ff.head_n);
      off_dist_code = off_len + 5'(stage_ff.len_ext_n);
      off_dist_ext  = off_dist_code + dfhe_pkg::DIST_CODE_BITS;
      tok_data.flush = stage_ff.is_flush;
      if (stage_ff.is_flush) begin
         tok_data.bits  = '0;
         tok_data.count = '0;
      end else if (stage_ff.is_match) begin
         tok_data.bits  = dfhe_pkg::TOK_BITS_W'(stage_ff.head_code)
                        | (dfhe_pkg::TOK_BITS_W'(stage_ff.len_ext) << off_len)
                        | (dfhe_pkg::TOK_BITS_W'(stage_ff.dist_rev) << off_dist_code)
                        | (dfhe_pkg::TOK_BITS_W'(stage_ff.dist_ext) << off_dist_ext);
         tok_data.count = off_dist_ext + 5'(stage_ff.dist_ext_n);
      end else begin
         tok_data.bits  = dfhe_pkg::TOK_BITS_W'(stage_ff.head_code);
         tok_data.count = off_len;
      end
   end

   assign tok_push = stage_valid_ff;

`ifndef NO_ASSERTIONS
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && tok_full) |=> (stage_valid_ff && $stable(stage_ff)))
      else $error("classified item changed while the token queue was full");
   a_token_nonempty: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !stage_ff.is_flush) |-> (tok_data.count >= 5'd3))
      else $error("token without bits for a coding item");
`endif

endmodule

/* hdl/dfhe_back.sv */
module dfhe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tok_valid,
   input  dfhe_pkg::token_type  tok_data,
   output logic                 tok_pop,
   output logic                 out_push,
   output dfhe_pkg::result_type out_data,
   input  logic                 out_full
);

   localparam int AW = dfhe_pkg::ACC_W;
   localparam int NW = dfhe_pkg::ACC_COUNT_W;

   logic [AW-1:0] acc_ff, acc_in;
   logic [NW-1:0] acc_n_ff, acc_n_in;
   logic [AW-1:0] after_acc;
   logic [NW-1:0] after_n;
   logic          emit, load;

   // A byte leaves and the next token merges in during the same cycle.
   assign emit = (acc_n_ff >= NW'(8)) && !out_full;

   always_comb begin
      after_acc = emit ? (acc_ff >> 8) : acc_ff;
      after_n   = emit ? (acc_n_ff - NW'(8)) : acc_n_ff;
      load      = tok_valid && (after_n < NW'(8));
      acc_in    = after_acc;
      acc_n_in  = after_n;
      if (load) begin
         if (tok_data.flush) begin
            acc_n_in = (after_n != '0) ? NW'(8) : '0;
         end else begin
            acc_in   = after_acc | (AW'(tok_data.bits) << after_n[2:0]);
            acc_n_in = after_n + NW'(tok_data.count);
         end
      end
   end

   assign tok_pop              = load;
   assign out_push             = emit;
   assign out_data.out_byte    = acc_ff[7:0];
   assign out_data.last_of_run = (acc_n_ff < NW'(16));

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         acc_n_ff <= '0;
      end else begin
         acc_ff   <= acc_in;
         acc_n_ff <= acc_n_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      acc_n_ff <= NW'(AW))
      else $error("bit count exceeds the accumulator");
   a_upper_zero: assert property (@(posedge clock) disable iff (reset)
      (acc_ff >> acc_n_ff) == '0)
      else $error("bits above the count are not zero");
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (out_push && !out_data.last_of_run) |=> (acc_n_ff >= NW'(8)))
      else $error("run ended without a last byte");
`endif

endmodule

/* hdl/deflate_fixed_huffman_encoder_unit.sv */
// Channel   Direction  Handshake            Payload
// req_      in         push / full          action, final_block, literal_byte,
//                                           copy_length, copy_distance
// rsp_      out        empty / pop          out_byte, last_of_run
//
// An item is taken every cycle while the token queue has room; unused action
// codes are taken and dropped. The bit packer sends one byte per cycle while
// the result queue has room; an item that completes bytes holds it until they
// are sent (a match completes up to four). Reset clears the pending bits and
// both queues. A stalled result side backs up the packer, then the token queue,
// then req_full.
module deflate_fixed_huffman_encoder_unit #(
   parameter int TOKEN_DEPTH  = dfhe_pkg::TOKEN_DEPTH,
   parameter int RESULT_DEPTH = dfhe_pkg::RESULT_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_action,
   input  logic        req_final_block,
   input  logic [7:0]  req_literal_byte,
   input  logic [8:0]  req_copy_length,
   input  logic [15:0] req_copy_distance,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run
);

   dfhe_pkg::token_type  tok_in_data, tok_out_data;
   logic                 tok_push, tok_full, tok_pop, tok_empty;
   dfhe_pkg::result_type res_in_data, res_out_data;
   logic                 res_push, res_full;

   dfhe_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_action        (req_action),
      .req_final_block   (req_final_block),
      .req_literal_byte  (req_literal_byte),
      .req_copy_length   (req_copy_length),
      .req_copy_distance (req_copy_distance),
      .tok_push          (tok_push),
      .tok_data          (tok_in_data),
      .tok_full          (tok_full)
   );

   dfhe_fifo #(
      .WIDTH ($bits(dfhe_pkg::token_type)),
      .DEPTH (TOKEN_DEPTH)
   ) u_token_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (tok_push),
      .push_data (tok_in_data),
      .full      (tok_full),
      .pop       (tok_pop),
      .pop_data  (tok_out_data),
      .empty     (tok_empty)
   );

   dfhe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (!tok_empty),
      .tok_data  (tok_out_data),
      .tok_pop   (tok_pop),
      .out_push  (res_push),
      .out_data  (res_in_data),
      .out_full  (res_full)
   );

   dfhe_fifo #(
      .WIDTH ($bits(dfhe_pkg::result_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_in_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_out_data),
      .empty     (rsp_empty)
   );

   assign rsp_out_byte    = res_out_data.out_byte;
   assign rsp_last_of_run = res_out_data.last_of_run;

endmodule
